[design/sbr_pkg.sv]
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types and constants for the stream byte reassembler.
// ----------------------------------------------------------------------------
package sbr_pkg;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int CNT_W       = 7;

  // Classified request, front to back.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] start;
    logic [32:0] pos;
    logic [32:0] end_p1;
    logic [31:0] eof_pos;
    logic        eof;
    logic        store_cand;
    logic        drain;
    logic [7:0]  value;
    logic [31:0] read_count;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             out_valid;
    logic             last;
    logic             stream_ended;
    logic [CNT_W-1:0] unassembled_count;
  } result_t;

endpackage

[design/sbr_front.sv]
// ----------------------------------------------------------------------------
// sbr_front
// Accepts input requests, decodes them and forms the position sums.
// ----------------------------------------------------------------------------
module sbr_front (
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [111:0]  s_tdata,
  input  logic [1:0]    s_tuser,
  input  logic          q_full,
  output logic          push,
  output sbr_pkg::cmd_t cmd
);
  import sbr_pkg::*;

  logic [1:0]  kind;
  logic [31:0] start;
  logic [15:0] len_raw;
  logic [15:0] len;
  logic [15:0] off;

  assign kind    = s_tuser;
  assign start   = s_tdata[31:0];
  assign len_raw = s_tdata[47:32];
  assign off     = s_tdata[63:48];
  assign len     = (kind == KIND_EMPTY) ? 16'd0 : len_raw;

  always_comb begin
    cmd.kind       = kind;
    cmd.start      = start;
    cmd.pos        = {1'b0, start} + {17'd0, off};
    cmd.end_p1     = {1'b0, start} + {17'd0, len} + 33'd1;
    cmd.eof_pos    = start + {16'd0, len};
    cmd.eof        = s_tdata[72];
    cmd.store_cand = (kind == KIND_BYTE) && (off < len);
    cmd.drain      = (kind == KIND_EMPTY) ||
                     ((kind == KIND_BYTE) && (({1'b0, off} + 17'd1) == {1'b0, len}));
    cmd.value      = s_tdata[71:64];
    cmd.read_count = s_tdata[104:73];
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

endmodule

[design/sbr_queue.sv]
// ----------------------------------------------------------------------------
// sbr_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module sbr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sbr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output sbr_pkg::cmd_t head,
  output logic          empty
);
  import sbr_pkg::*;

  cmd_t             entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/sbr_back.sv]
// ----------------------------------------------------------------------------
// sbr_back
// Window checks, byte store, run scan and in-order drain with output register.
// ----------------------------------------------------------------------------
module sbr_back #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  sbr_pkg::cmd_t    q_head,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output sbr_pkg::result_t m_res
);
  import sbr_pkg::*;

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_C     = CNT_W'(CAPACITY);
  localparam logic [32:0]      CAP_M1    = 33'(CAPACITY - 1);
  localparam logic [SW-1:0]    SLOT_LAST = SW'(CAPACITY - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_STAT = 2'd3;

  logic [1:0]          state;
  logic [31:0]         wr_count;
  logic [31:0]         reader;
  logic [CNT_W-1:0]    held;
  logic                eof_seen;
  logic [31:0]         eof_pos;
  logic                ended;
  logic [CAPACITY-1:0] valid;
  logic [SW-1:0]       wr_slot;
  logic [SW-1:0]       scan_slot;
  logic [CNT_W-1:0]    scan_cnt;
  logic [CNT_W-1:0]    remain;
  logic                o_valid;
  result_t             o_res;

  logic [7:0]          store [CAPACITY];
  logic [7:0]          mem_q;

  logic                out_free;
  logic [32:0]         maxpos;
  logic [32:0]         wr33;
  logic                seg;
  logic                drop;
  logic                in_win;
  logic [32:0]         diff;
  logic [CNT_W-1:0]    slot_sum;
  logic [CNT_W-1:0]    slot_wrap;
  logic [SW-1:0]       st_slot;
  logic                do_store;
  logic                do_drain;
  logic                emit;
  logic                step_ok;
  logic                end_hit;
  logic [CNT_W-1:0]    held_dec;
  logic [SW-1:0]       wr_slot_next;
  logic                res_load;
  result_t             res_d;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s == SLOT_LAST) ? '0 : s + 1'b1;
    return r;
  endfunction

  assign out_free = !o_valid || m_tready;
  assign pop      = (state == ST_IDLE) && !q_empty && out_free;
  assign maxpos   = {1'b0, reader} + CAP_M1;
  assign wr33     = {1'b0, wr_count};
  assign seg      = (q_head.kind == KIND_BYTE) || (q_head.kind == KIND_EMPTY);
  assign drop     = ({1'b0, q_head.start} > maxpos) || (q_head.end_p1 <= wr33);
  assign in_win   = (q_head.pos >= wr33) && (q_head.pos <= maxpos);

  // position is within one window of wr_count, so one wrap suffices
  assign diff      = q_head.pos - wr33;
  assign slot_sum  = CNT_W'(wr_slot) + diff[CNT_W-1:0];
  assign slot_wrap = (slot_sum >= CAP_C) ? slot_sum - CAP_C : slot_sum;
  assign st_slot   = slot_wrap[SW-1:0];

  assign do_store = pop && seg && !drop && q_head.store_cand && in_win && !valid[st_slot];
  assign do_drain = pop && seg && !drop && q_head.drain;

  assign emit     = (state == ST_EMIT) && out_free;
  assign step_ok  = (scan_cnt < CAP_C) && valid[scan_slot];
  assign end_hit  = eof_seen && ((wr_count + 32'(scan_cnt)) == eof_pos);
  assign held_dec = (held != '0) ? held - 1'b1 : held;
  assign wr_slot_next = emit ? slot_inc(wr_slot) : wr_slot;

  always_ff @(posedge clk) begin
    if (do_store) begin
      store[st_slot] <= q_head.value;
    end
    mem_q <= store[wr_slot_next];
  end

  always_comb begin
    res_load                = 1'b0;
    res_d.out_byte          = 8'd0;
    res_d.out_valid         = 1'b0;
    res_d.last              = 1'b1;
    res_d.stream_ended      = ended;
    res_d.unassembled_count = held;
    if (pop && !do_drain) begin
      res_load                = 1'b1;
      res_d.unassembled_count = held + CNT_W'(do_store);
    end
    if ((state == ST_STAT) && out_free) begin
      res_load = 1'b1;
    end
    if (emit) begin
      res_load                = 1'b1;
      res_d.out_byte          = mem_q;
      res_d.out_valid         = 1'b1;
      res_d.last              = (remain == CNT_W'(1));
      res_d.unassembled_count = held_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      o_res <= res_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_count  <= '0;
      reader    <= '0;
      held      <= '0;
      eof_seen  <= 1'b0;
      eof_pos   <= '0;
      ended     <= 1'b0;
      valid     <= '0;
      wr_slot   <= '0;
      scan_slot <= '0;
      scan_cnt  <= '0;
      remain    <= '0;
      o_valid   <= 1'b0;
    end else begin
      if (res_load) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (q_head.kind == KIND_READ) begin
              reader <= (q_head.read_count < wr_count) ? q_head.read_count : wr_count;
            end
            if (seg && !drop && q_head.eof) begin
              eof_seen <= 1'b1;
              eof_pos  <= q_head.eof_pos;
            end
            if (do_store) begin
              valid[st_slot] <= 1'b1;
              held           <= held + 1'b1;
            end
            if (do_drain) begin
              state     <= ST_SCAN;
              scan_slot <= wr_slot;
              scan_cnt  <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (step_ok) begin
            scan_cnt  <= scan_cnt + 1'b1;
            scan_slot <= slot_inc(scan_slot);
          end else begin
            if (end_hit) begin
              ended <= 1'b1;
            end
            remain <= scan_cnt;
            state  <= (scan_cnt == '0) ? ST_STAT : ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            valid[wr_slot] <= 1'b0;
            wr_count       <= wr_count + 32'd1;
            wr_slot        <= wr_slot_next;
            held           <= held_dec;
            remain         <= remain - 1'b1;
            if (remain == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_STAT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = o_valid;
  assign m_res    = o_res;

endmodule

[design/stream_byte_reassembler.sv]
// ----------------------------------------------------------------------------
// stream_byte_reassembler
// Path: a status result passes the request queue and the output register;
// run bytes pass the queue, the run scan, the store read and output registers.
// Throughput: one request per cycle while none drains and the output accepts;
// a draining request holds the back end for the run scan, then one byte per
// cycle while the output accepts, or a status result if the run is empty.
// Reset: synchronous, clears counters, slot valid bits, queue and output.
// ----------------------------------------------------------------------------
module stream_byte_reassembler #(
  parameter int CAPACITY = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // seg_start, seg_length, byte_offset, byte_value, seg_eof, read_count, pad
  input  logic [111:0] s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_byte, stream_ended, unassembled_count
  output logic [15:0]  m_axis_tdata,
  // out_valid
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);
  import sbr_pkg::*;

  cmd_t    push_cmd;
  cmd_t    q_head;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  result_t res;

  sbr_front u_front (
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .q_full   (q_full),
    .push     (q_push),
    .cmd      (push_cmd)
  );

  sbr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  sbr_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .pop      (q_pop),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_res    (res)
  );

  assign m_axis_tdata = {res.unassembled_count, res.stream_ended, res.out_byte};
  assign m_axis_tuser = res.out_valid;
  assign m_axis_tlast = res.last;

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("status result not marked last");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
    else $error("status result carries a byte");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_end_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tdata[8]
      |=> !m_axis_tvalid || m_axis_tdata[8])
    else $error("stream end dropped");

endmodule

[tb/sbr_checker.sv]
// ----------------------------------------------------------------------------
// sbr_checker
// Watches both stream ports of the byte reassembler. Every accepted request
// runs through a local model of the reassembly window, which queues the
// output beats it should cause; every accepted output beat is compared field
// by field with the oldest queued beat.
// ----------------------------------------------------------------------------
module sbr_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // seg_start, seg_length, byte_offset, byte_value, seg_eof, read_count, pad
  input  logic [111:0] s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_byte, stream_ended, unassembled_count
  input  logic [15:0]  m_axis_tdata,
  // out_valid
  input  logic         m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           mismatches,
  output int           pending,
  output logic [31:0]  stream_pos
);
  import sbr_pkg::*;

  localparam int WINDOW = 64;

  logic [7:0]  byte_mem [WINDOW];
  logic        slot_full [WINDOW];
  logic [31:0] wr_count;
  logic [31:0] rd_count;
  logic [31:0] eof_at;
  logic [6:0]  held;
  logic        eof_seen;
  logic        ended;
  result_t     emit_q [$];
  int          beat_no;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("[%0t] beat %0d: %s want 0x%0h got 0x%0h", $realtime, beat_no, what,
             want, got);
  endtask

  function automatic void push_beat(input logic [7:0] b, input logic v, input logic l);
    result_t r;
    r.out_byte          = b;
    r.out_valid         = v;
    r.last              = l;
    r.stream_ended      = ended;
    r.unassembled_count = held;
    emit_q = {emit_q, r};
  endfunction

  function automatic void absorb_request(input logic [1:0] kind, input logic [111:0] d);
    logic [63:0] start;
    logic [63:0] len;
    logic [63:0] off;
    logic [63:0] pos;
    logic [63:0] wr;
    logic [63:0] max_pos;
    logic [31:0] rd;
    logic [7:0]  val;
    logic [7:0]  run_bytes [$];
    logic        eof;
    logic        drain;
    start = {32'b0, d[31:0]};
    len   = {48'b0, d[47:32]};
    off   = {48'b0, d[63:48]};
    val   = d[71:64];
    eof   = d[72];
    rd    = d[104:73];
    if (kind == KIND_READ) begin
      rd_count = (rd < wr_count) ? rd : wr_count;
      push_beat(8'h00, 1'b0, 1'b1);
    end else if (kind != KIND_BYTE && kind != KIND_EMPTY) begin
      push_beat(8'h00, 1'b0, 1'b1);
    end else begin
      if (kind == KIND_EMPTY)
        len = '0;
      wr      = {32'b0, wr_count};
      max_pos = {32'b0, rd_count} + 64'(WINDOW - 1);
      if (start > max_pos || start + len + 1 <= wr) begin
        push_beat(8'h00, 1'b0, 1'b1);
      end else begin
        if (eof) begin
          eof_seen = 1'b1;
          eof_at   = start[31:0] + len[31:0];
        end
        drain = (kind == KIND_EMPTY);
        if (kind == KIND_BYTE && off < len) begin
          pos = start + off;
          if (pos >= wr && pos <= max_pos && !slot_full[pos[5:0]]) begin
            slot_full[pos[5:0]] = 1'b1;
            byte_mem[pos[5:0]]  = val;
            held++;
          end
          drain = (off + 1 == len);
        end
        if (!drain) begin
          push_beat(8'h00, 1'b0, 1'b1);
        end else begin
          while (run_bytes.size() < WINDOW && slot_full[wr_count[5:0]]) begin
            run_bytes = {run_bytes, byte_mem[wr_count[5:0]]};
            slot_full[wr_count[5:0]] = 1'b0;
            wr_count++;
          end
          if (eof_seen && wr_count == eof_at)
            ended = 1'b1;
          if (run_bytes.size() == 0) begin
            push_beat(8'h00, 1'b0, 1'b1);
          end else begin
            foreach (run_bytes[k]) begin
              if (held > 0)
                held--;
              push_beat(run_bytes[k], 1'b1, k == run_bytes.size() - 1);
            end
          end
        end
      end
    end
  endfunction

  task automatic check_beat();
    result_t want;
    if (emit_q.size() == 0) begin
      report_mismatch("result with nothing expected", '0,
                      {14'b0, m_axis_tuser, m_axis_tlast, m_axis_tdata});
    end else begin
      want = emit_q.pop_front();
      if (m_axis_tdata[7:0] != want.out_byte)
        report_mismatch("out_byte", 32'(want.out_byte), 32'(m_axis_tdata[7:0]));
      if (m_axis_tuser != want.out_valid)
        report_mismatch("out_valid", 32'(want.out_valid), 32'(m_axis_tuser));
      if (m_axis_tlast != want.last)
        report_mismatch("last", 32'(want.last), 32'(m_axis_tlast));
      if (m_axis_tdata[8] != want.stream_ended)
        report_mismatch("stream_ended", 32'(want.stream_ended), 32'(m_axis_tdata[8]));
      if (m_axis_tdata[15:9] != want.unassembled_count)
        report_mismatch("unassembled_count", 32'(want.unassembled_count),
                        32'(m_axis_tdata[15:9]));
    end
    beat_no++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_full[i]) begin
        slot_full[i] = 1'b0;
        byte_mem[i]  = 8'h00;
      end
      wr_count = '0;
      rd_count = '0;
      eof_at   = '0;
      held     = '0;
      eof_seen = 1'b0;
      ended    = 1'b0;
      emit_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_beat();
      if (s_axis_tvalid && s_axis_tready)
        absorb_request(s_axis_tuser, s_axis_tdata);
    end
    pending    <= emit_q.size();
    stream_pos <= wr_count;
  end

endmodule

[tb/tb_stream_byte_reassembler.sv]
// ----------------------------------------------------------------------------
// tb_stream_byte_reassembler
// Drives segment bytes, empty segments and reader updates into the byte
// reassembler: a directed opening, then mostly in-order, overlapping and
// swapped segments near the stream position with some noise. Both sides
// idle at random; sbr_checker predicts and compares the output beats.
// ----------------------------------------------------------------------------
module tb_stream_byte_reassembler;
  import sbr_pkg::*;

  localparam logic [1:0] KIND_RSVD   = 2'd3;
  localparam int         ITEM_TARGET = 310;
  localparam int         IDLE_LIMIT  = 2000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = KIND_BYTE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  int           mismatches;
  int           pending;
  logic [31:0]  stream_pos;

  int           items = 0;
  int           idle_cycles = 0;
  int           stall_left = 0;
  bit           calm = 1'b0;
  bit           tail = 1'b0;

  always #5 clk = ~clk;

  stream_byte_reassembler #(.CAPACITY(64)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sbr_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .pending       (pending),
    .stream_pos    (stream_pos)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return 0;
    if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_req(input logic [1:0] kind, input logic [31:0] start,
                          input logic [15:0] len, input logic [15:0] off,
                          input logic [7:0] val, input logic eof, input logic [31:0] rd);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'b0, rd, eof, val, off, len, start};
    do @(posedge clk); while (!s_axis_tready);
    items++;
  endtask

  task automatic send_segment(input logic [31:0] start, input int len, input logic eof,
                              input bit shuffle);
    int order [$];
    int t;
    int tmp;
    if (len == 0) begin
      push_req(KIND_EMPTY, start, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), eof, $urandom);
    end else begin
      for (int j = 0; j < len; j++)
        order = {order, j};
      if (shuffle) begin
        for (int j = len - 1; j > 0; j--) begin
          t        = $urandom_range(0, j);
          tmp      = order[j];
          order[j] = order[t];
          order[t] = tmp;
        end
      end
      foreach (order[j])
        push_req(KIND_BYTE, start, 16'(len), 16'(order[j]), 8'($urandom_range(0, 255)),
                 eof, $urandom);
    end
  endtask

  // output side back-pressure
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (tail || calm) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          r;
    int          la;
    int          lb;
    int          back;
    logic [31:0] base;
    logic        eof;
    bit          shuf;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed opening
    push_req(KIND_READ,  32'd0, 16'd0, 16'd0, 8'h00, 1'b0, 32'd0);
    push_req(KIND_RSVD,  '1, '1, '1, '1, 1'b1, '1);
    push_req(KIND_EMPTY, 32'd0, 16'd5, 16'd0, 8'h00, 1'b0, 32'd0);
    push_req(KIND_BYTE,  32'd0, 16'd3, 16'd1, 8'h11, 1'b0, 32'd0);
    push_req(KIND_BYTE,  32'd0, 16'd3, 16'd2, 8'h22, 1'b0, 32'd0);  // last, hole below
    push_req(KIND_BYTE,  32'd0, 16'd3, 16'd0, 8'h00, 1'b0, 32'd0);
    push_req(KIND_EMPTY, 32'd0, 16'd0, 16'd0, 8'h00, 1'b0, 32'd0);
    push_req(KIND_BYTE,  32'd3, 16'd2, 16'd5, 8'h77, 1'b0, 32'd0);  // offset past length
    push_req(KIND_BYTE,  32'd3, 16'd2, 16'd0, 8'hff, 1'b0, 32'd0);
    push_req(KIND_BYTE,  32'd3, 16'd2, 16'd0, 8'h5a, 1'b0, 32'd0);  // first value wins
    push_req(KIND_BYTE,  32'd3, 16'd2, 16'd1, 8'h80, 1'b0, 32'd0);
    push_req(KIND_BYTE,  32'd0, 16'd1, 16'd0, 8'h33, 1'b0, 32'd0);  // stale segment
    push_req(KIND_BYTE,  '1, '1, '1, '1, 1'b1, '1);                // far beyond window
    push_req(KIND_READ,  32'd0, 16'd0, 16'd0, 8'h00, 1'b0, '1);
    push_req(KIND_BYTE,  32'd68, 16'd1, 16'd0, 8'h68, 1'b0, 32'd0); // top of window
    push_req(KIND_BYTE,  32'd69, 16'd1, 16'd0, 8'h69, 1'b0, 32'd0);
    push_req(KIND_BYTE,  32'd5, '1, 16'd0, 8'h42, 1'b0, 32'd0);
    push_req(KIND_BYTE,  32'd6, 16'd2, 16'd1, 8'h43, 1'b0, 32'd0);
    push_req(KIND_BYTE,  32'd6, 16'd2, 16'd0, 8'h44, 1'b0, 32'd0);
    push_req(KIND_EMPTY, 32'd6, 16'd0, 16'd0, 8'h00, 1'b0, 32'd0);
    push_req(KIND_EMPTY, 32'd60, 16'd0, 16'd0, 8'h00, 1'b1, 32'd0);
    push_req(KIND_READ,  32'd0, 16'd0, 16'd0, 8'h00, 1'b0, 32'd8);

    while (items < ITEM_TARGET) begin
      if ($urandom_range(0, 39) == 0)
        calm = !calm;
      r    = $urandom_range(0, 99);
      base = stream_pos;
      if (r < 60) begin
        la   = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 12);
        eof  = ($urandom_range(0, 29) == 0);
        shuf = ($urandom_range(0, 3) == 0);
        if (r < 20) begin
          // later half first, then the half that closes the hole
          lb = (la >= 20) ? $urandom_range(20, 31) : $urandom_range(1, 10);
          send_segment(base + la, lb, eof, shuf);
          send_segment(base, la, 1'b0, shuf);
        end else begin
          back = $urandom_range(0, 3);
          if (back > base)
            back = base;
          send_segment(base - back, la, eof, shuf);
        end
        if ($urandom_range(0, 1))
          push_req(KIND_READ, $urandom, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), stream_pos + $urandom_range(0, 3));
      end else if (r < 72) begin
        push_req(KIND_READ, $urandom, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), base + $urandom_range(0, 4) - 2);
      end else if (r < 82) begin
        send_segment(base + $urandom_range(0, 2), 0, $urandom_range(0, 19) == 0, 1'b0);
      end else begin
        push_req(2'($urandom_range(0, 3)),
                 $urandom_range(0, 1) ? $urandom : base + $urandom_range(0, 70),
                 16'($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 8)),
                 16'($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 8)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), $urandom);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    tail = 1'b1;
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[stream_byte_reassembler.f]
design/sbr_pkg.sv
design/sbr_front.sv
design/sbr_queue.sv
design/sbr_back.sv
design/stream_byte_reassembler.sv
tb/sbr_checker.sv
tb/tb_stream_byte_reassembler.sv
